[sv/aged_packet_ring_with_byte_cap_defines.svh]
// assertion helpers shared by the ring block
`ifndef AGED_PACKET_RING_WITH_BYTE_CAP_DEFINES_SVH
`define AGED_PACKET_RING_WITH_BYTE_CAP_DEFINES_SVH

// condition must hold at every edge out of reset
`define APRBC_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define APRBC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define APRBC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/aprbc_pkg.sv]
package aprbc_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int SEC_W      = 32;
  localparam int USEC_W     = 20;
  localparam int LEN_W      = 16;
  localparam int HANDLE_W   = 32;
  localparam int CTR_W      = 32;
  localparam int BYTES_W    = 33;
  localparam int COUNT_W    = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PDATA_W-1:0] RETENTION_RESET = 32'd3600;
  localparam logic [PDATA_W-1:0] BUDGET_RESET    = 32'd1048576;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]  SLOT_FULL = CNT_W'(SLOT_COUNT);

  // operation codes
  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_RETENTION = 1'b0;
  localparam logic REG_BUDGET    = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [SEC_W-1:0]    event_sec;
    logic [USEC_W-1:0]   event_usec;
    logic [SEC_W-1:0]    until_sec;
    logic [USEC_W-1:0]   until_usec;
    logic                lower_bound_on;
    logic                upper_bound_on;
    logic [LEN_W-1:0]    packet_length;
    logic [HANDLE_W-1:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] entry_handle;
    logic [SEC_W-1:0]    entry_sec;
    logic [USEC_W-1:0]   entry_usec;
    logic                entry_valid;
    logic                last_entry;
    logic [COUNT_W-1:0]  stored_count;
    logic [BYTES_W-1:0]  stored_bytes;
    logic [CTR_W-1:0]    evicted_total;
    logic [CTR_W-1:0]    recorded_total;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SEC_W-1:0]    sec;
    logic [USEC_W-1:0]   usec;
    logic [LEN_W-1:0]    len;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_CAP_RD,
    ST_CAP_CHK,
    ST_STORE,
    ST_REC_OUT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_RECORD,
    EMIT_PENDING,
    EMIT_FINAL
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  rd_scan;
    logic  evict;
    logic  store;
    logic  scan_next;
    logic  keep;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic               age_old;
    logic               over_cap;
    logic               match;
    logic               scan_done;
    logic               have_pending;
    logic               out_free;
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] bytes;
  } dp_stat_t;

endpackage

[sv/aprbc_datapath.sv]
module aprbc_datapath
  import aprbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  in_item_t           item,
  input  logic [PDATA_W-1:0] age_window,
  input  logic [PDATA_W-1:0] byte_budget,
  input  dp_cmd_t            cmd,
  input  logic               result_stall,
  output dp_stat_t           stat,
  output logic               result_valid,
  output out_item_t          result
);

  slot_t mem [SLOT_COUNT];
  slot_t rd_data;

  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  write_pointer;
  logic [SLOT_W-1:0]  scan_ptr;
  logic [CNT_W-1:0]   occupancy;
  logic [CNT_W-1:0]   scan_cnt;
  logic [BYTES_W-1:0] byte_total;
  logic [CTR_W-1:0]   eviction_counter;
  logic [CTR_W-1:0]   record_counter;
  logic               have_pending;

  in_item_t           cur;
  logic               cut_ok;
  logic [SEC_W-1:0]   cutoff;
  slot_t              pending;

  logic               lo_fail;
  logic               hi_fail;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    return (p == SLOT_LAST) ? '0 : p + 1'b1;
  endfunction

  assign rd_addr = cmd.rd_scan ? scan_ptr : head;

  // descriptor memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[write_pointer] <= '{cur.packet_handle, cur.event_sec, cur.event_usec,
                              cur.packet_length};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head             <= '0;
      write_pointer    <= '0;
      occupancy        <= '0;
      byte_total       <= '0;
      eviction_counter <= '0;
      record_counter   <= '0;
      scan_ptr         <= '0;
      scan_cnt         <= '0;
      have_pending     <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (cmd.evict) begin
        head             <= slot_inc(head);
        occupancy        <= occupancy - 1'b1;
        byte_total       <= byte_total - BYTES_W'(rd_data.len);
        eviction_counter <= eviction_counter + 1'b1;
      end else if (cmd.store) begin
        write_pointer  <= slot_inc(write_pointer);
        occupancy      <= occupancy + 1'b1;
        byte_total     <= byte_total + BYTES_W'(cur.packet_length);
        record_counter <= record_counter + 1'b1;
      end
      if (cmd.load) begin
        scan_ptr     <= head;
        scan_cnt     <= '0;
        have_pending <= 1'b0;
      end else begin
        if (cmd.scan_next) begin
          scan_ptr <= slot_inc(scan_ptr);
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (cmd.keep) begin
          have_pending <= 1'b1;
        end
      end
      if (cmd.emit != EMIT_NONE) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur    <= item;
      cut_ok <= item.event_sec >= age_window;
      cutoff <= item.event_sec - age_window;
    end
    if (cmd.keep) begin
      pending <= rd_data;
    end
    if (cmd.emit != EMIT_NONE) begin
      result.stored_count   <= COUNT_W'(occupancy);
      result.stored_bytes   <= byte_total;
      result.evicted_total  <= eviction_counter;
      result.recorded_total <= record_counter;
      unique case (cmd.emit)
        EMIT_PENDING: begin
          result.entry_handle <= pending.handle;
          result.entry_sec    <= pending.sec;
          result.entry_usec   <= pending.usec;
          result.entry_valid  <= 1'b1;
          result.last_entry   <= 1'b0;
        end
        EMIT_FINAL: begin
          result.entry_handle <= have_pending ? pending.handle : '0;
          result.entry_sec    <= have_pending ? pending.sec : '0;
          result.entry_usec   <= have_pending ? pending.usec : '0;
          result.entry_valid  <= have_pending;
          result.last_entry   <= 1'b1;
        end
        EMIT_RECORD, EMIT_NONE: begin
          result.entry_handle <= '0;
          result.entry_sec    <= '0;
          result.entry_usec   <= '0;
          result.entry_valid  <= 1'b0;
          result.last_entry   <= 1'b1;
        end
      endcase
    end
  end

  assign lo_fail = cur.lower_bound_on &&
                   ({rd_data.sec, rd_data.usec} < {cur.event_sec, cur.event_usec});
  assign hi_fail = cur.upper_bound_on &&
                   ({rd_data.sec, rd_data.usec} > {cur.until_sec, cur.until_usec});

  always_comb begin
    stat.empty        = occupancy == '0;
    stat.full         = occupancy == SLOT_FULL;
    stat.age_old      = cut_ok && (rd_data.sec < cutoff);
    stat.over_cap     = ({1'b0, byte_total} + (BYTES_W + 1)'(cur.packet_length))
                        > (BYTES_W + 1)'(byte_budget);
    stat.match        = !lo_fail && !hi_fail;
    stat.scan_done    = scan_cnt == occupancy;
    stat.have_pending = have_pending;
    stat.out_free     = !result_valid || !result_stall;
    stat.count        = occupancy;
    stat.bytes        = byte_total;
  end

endmodule

[sv/aprbc_ctrl.sv]
module aprbc_ctrl
  import aprbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_op,
  output logic     item_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (item_op == OP_EXTRACT) ? ST_SCAN_RD : ST_AGE_RD;
        end
      end
      ST_AGE_RD:  state_next = ST_AGE_CHK;
      ST_AGE_CHK: begin
        state_next = (!stat.empty && stat.age_old) ? ST_AGE_RD : ST_CAP_CHK;
      end
      ST_CAP_RD:  state_next = ST_CAP_CHK;
      ST_CAP_CHK: begin
        state_next = (!stat.empty && stat.over_cap) ? ST_CAP_RD : ST_STORE;
      end
      ST_STORE:   state_next = ST_REC_OUT;
      ST_REC_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_next = stat.scan_done ? ST_SCAN_END : ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!(stat.match && stat.have_pending && !stat.out_free)) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_END: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = state != ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        cmd.load = item_valid;
      end
      ST_AGE_CHK: begin
        cmd.evict = !stat.empty && stat.age_old;
      end
      ST_CAP_CHK: begin
        priority if (!stat.empty && stat.over_cap) begin
          cmd.evict = 1'b1;
        end else if (stat.full) begin
          cmd.evict = 1'b1;
        end else begin
          cmd.evict = 1'b0;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
      end
      ST_REC_OUT: begin
        cmd.emit = stat.out_free ? EMIT_RECORD : EMIT_NONE;
      end
      ST_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
      end
      ST_SCAN_CHK: begin
        cmd.rd_scan = 1'b1;
        if (!stat.match) begin
          cmd.scan_next = 1'b1;
        end else if (!stat.have_pending) begin
          cmd.keep      = 1'b1;
          cmd.scan_next = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit      = EMIT_PENDING;
          cmd.keep      = 1'b1;
          cmd.scan_next = 1'b1;
        end
      end
      ST_SCAN_END: begin
        cmd.emit = stat.out_free ? EMIT_FINAL : EMIT_NONE;
      end
      ST_AGE_RD, ST_CAP_RD: begin
        cmd.rd_scan = 1'b0;
      end
    endcase
  end

endmodule

[sv/aged_packet_ring_with_byte_cap.sv]
// Ring of up to 64 packet descriptors (handle, timestamp, length) for one stream.
// A record beat evicts the oldest entries that have aged past the age window,
// then the oldest ones while held bytes plus the new length exceed byte_budget,
// then one more if the ring is still full, and stores the packet (even an
// oversized one); it answers with one result beat carrying the counters.
// An extract beat returns every held entry inside the enabled time bounds,
// oldest first, with last_entry on the final beat, or a single beat with
// entry_valid low when nothing matches. One item is worked at a time, and
// either kind of item can be held up while the result side stalls. Entries
// are walked through the descriptor memory's single registered read port,
// one address then one check per entry. The next item is taken while the
// last result still waits.
// Registers: 0x0 age_window in seconds (reset 3600), 0x4 byte_budget (reset 1048576).
`include "aged_packet_ring_with_byte_cap_defines.svh"

module aged_packet_ring_with_byte_cap
  import aprbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  in_item_t           item,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output out_item_t          result,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PDATA_W-1:0] age_window;
  logic [PDATA_W-1:0] byte_budget;
  logic               reg_index;
  logic               reg_write;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file, single wait-free access
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_window  <= RETENTION_RESET;
      byte_budget <= BUDGET_RESET;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_RETENTION: age_window  <= pwdata;
        REG_BUDGET:    byte_budget <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RETENTION: prdata = age_window;
      REG_BUDGET:    prdata = byte_budget;
    endcase
  end

  // sequencer: eviction walk, store and range scan
  aprbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_op    (item.operation),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // descriptor memory, ring pointers, counters and result register
  aprbc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .age_window   (age_window),
    .byte_budget  (byte_budget),
    .cmd          (cmd),
    .result_stall (result_stall),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

  // ring never holds more than its slots
  `APRBC_ASSERT_NOW(a_occ_bound, stat.count <= SLOT_FULL, "occupancy above slot count")
  // bytes are exactly the held lengths, so an empty ring holds none
  `APRBC_ASSERT_IMP(a_empty_no_bytes, stat.count == '0, stat.bytes == '0, "bytes held by empty ring")
  // a beat without an entry is always the closing beat of its item
  `APRBC_ASSERT_IMP(a_invalid_is_last, result_valid && !result.entry_valid, result.last_entry, "entry-less beat not last")
  // a store always leaves the ring non-empty
  `APRBC_ASSERT_NXT(a_store_fills, cmd.store, stat.count != '0, "ring empty after store")

endmodule
